>>> hw/rtl/tpa_pkg.sv
// Shared types and constants for the triangle primitive assembly block.
package tpa_pkg;

    // Width of a vertex index field on the ports.
    localparam int VTX_W = 32;
    // Number of low index bits that take part in assembly.
    localparam int INDEX_BITS = 32;

    typedef enum logic [1:0] {
        PRIM_LIST  = 2'd0,
        PRIM_STRIP = 2'd1,
        PRIM_FAN   = 2'd2,
        PRIM_OTHER = 2'd3
    } t_prim_type;

    typedef enum logic [1:0] {
        CFG_PRIM_TYPE    = 2'd0,
        CFG_VERTEX_LIMIT = 2'd1,
        CFG_BASE_OFFSET  = 2'd2
    } t_cfg_index;

    // Triangle formed from one index, before the range check and offset.
    typedef struct packed {
        logic             valid;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic [VTX_W-1:0] c;
    } t_tri_cand;

endpackage

>>> hw/rtl/triangle_primitive_assembly_core.sv
// Top level of the triangle primitive assembly block.
//
// This block turns a stream of vertex indices into triangles given as index
// triples. The primitive type register picks triangle list (groups of three,
// a trailing partial group is dropped), triangle strip (one triangle per index
// from the third on, first two corners swapped on odd positions) or triangle
// fan (first index, previous index, current index); the fourth type emits
// nothing. A triangle is sent only when all three raw corners are below the
// vertex limit, and the base offset is then added to each corner, wrapping at
// 32 bits. An index with tlast set ends the primitive and clears the state.
// One index is accepted every clock cycle unless the input is stalled: an
// item is held in the input register, where the assembly state and the corner
// compare and offset adders work on it, and the triangle is then loaded into
// the result register, from which the output takes it. Only a triangle held in
// the result register while the output is not ready stalls the input. The
// output ready feeds input ready combinationally through one stage of gating.
// Configuration registers must be written only while no item is in flight;
// a prim_type write does not clear the assembly state.
module triangle_primitive_assembly_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [tpa_pkg::VTX_W-1:0]   i_cfg_data,

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0 up: vertex_index[31:0].
    input  logic [tpa_pkg::VTX_W-1:0]   s_axis_tdata,
    input  logic                        s_axis_tlast,

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // Fields from bit 0 up: corner_a[31:0], corner_b[63:32], corner_c[95:64].
    output logic [3*tpa_pkg::VTX_W-1:0] m_axis_tdata
);

    tpa_pkg::t_prim_type       r_prim_type;
    logic [tpa_pkg::VTX_W-1:0] r_vertex_limit;
    logic [tpa_pkg::VTX_W-1:0] r_base_offset;

    logic                      r_in_valid;
    logic [tpa_pkg::VTX_W-1:0] r_in_index;
    logic                      r_in_last;

    logic                      w_stage_ready;
    logic                      w_advance;
    logic [tpa_pkg::VTX_W-1:0] w_index;
    tpa_pkg::t_tri_cand        w_cand;

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prim_type    <= tpa_pkg::PRIM_LIST;
            r_vertex_limit <= '0;
            r_base_offset  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tpa_pkg::CFG_PRIM_TYPE:    r_prim_type    <= tpa_pkg::t_prim_type'(i_cfg_data[1:0]);
                tpa_pkg::CFG_VERTEX_LIMIT: r_vertex_limit <= i_cfg_data;
                tpa_pkg::CFG_BASE_OFFSET:  r_base_offset  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The input register moves on whenever the result register can take its item.
    assign w_advance     = r_in_valid && w_stage_ready;
    assign s_axis_tready = !r_in_valid || w_stage_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_index <= s_axis_tdata;
            r_in_last  <= s_axis_tlast;
        end
    end

    // Only the low index bits take part in assembly.
    assign w_index = tpa_pkg::VTX_W'(r_in_index[tpa_pkg::INDEX_BITS-1:0]);

    tpa_assembler u_assembler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_index     (w_index),
        .i_last      (r_in_last),
        .i_prim_type (r_prim_type),
        .o_cand      (w_cand)
    );

    tpa_emit_stage u_emit_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_advance),
        .i_cand         (w_cand),
        .i_vertex_limit (r_vertex_limit),
        .i_base_offset  (r_base_offset),
        .o_ready        (w_stage_ready),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

endmodule

>>> hw/rtl/tpa_assembler.sv
// Primitive state tracking and triangle formation for list, strip and fan modes.
module tpa_assembler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic [tpa_pkg::VTX_W-1:0]  i_index,
    input  logic                       i_last,
    input  tpa_pkg::t_prim_type        i_prim_type,
    output tpa_pkg::t_tri_cand         o_cand
);

    logic [tpa_pkg::VTX_W-1:0] r_first, n_first;
    logic [tpa_pkg::VTX_W-1:0] r_older, n_older;
    logic [tpa_pkg::VTX_W-1:0] r_newer, n_newer;
    logic [1:0]                r_phase, n_phase;
    logic                      r_odd,   n_odd;

    always_comb begin
        n_first = r_first;
        n_older = r_older;
        n_newer = r_newer;
        n_phase = r_phase;
        n_odd   = ~r_odd;
        o_cand  = '{valid: 1'b0, a: r_older, b: r_newer, c: i_index};

        if (i_prim_type == tpa_pkg::PRIM_LIST) begin
            case (r_phase)
                2'd0: begin
                    n_older = i_index;
                    n_phase = 2'd1;
                end
                2'd1: begin
                    n_newer = i_index;
                    n_phase = 2'd2;
                end
                default: begin
                    o_cand.valid = 1'b1;
                    n_phase      = 2'd0;
                end
            endcase
        end else begin
            if (r_phase inside {2'd2, 2'd3}) begin
                case (i_prim_type)
                    tpa_pkg::PRIM_STRIP: begin
                        o_cand.valid = 1'b1;
                        if (r_odd) begin
                            // Odd positions swap the first two corners to keep winding.
                            o_cand.a = r_newer;
                            o_cand.b = r_older;
                        end
                    end
                    tpa_pkg::PRIM_FAN: begin
                        o_cand.valid = 1'b1;
                        o_cand.a     = r_first;
                    end
                    default: begin
                        o_cand.valid = 1'b0;
                    end
                endcase
            end else begin
                if (r_phase == 2'd0) begin
                    n_first = i_index;
                end
                n_phase = r_phase + 2'd1;
            end
            n_older = r_newer;
            n_newer = i_index;
        end

        if (i_last) begin
            n_first = '0;
            n_older = '0;
            n_newer = '0;
            n_phase = 2'd0;
            n_odd   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_older <= '0;
            r_newer <= '0;
            r_phase <= 2'd0;
            r_odd   <= 1'b0;
        end else if (i_advance) begin
            r_first <= n_first;
            r_older <= n_older;
            r_newer <= n_newer;
            r_phase <= n_phase;
            r_odd   <= n_odd;
        end
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("position phase left its range");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_last) |=> (r_phase == 2'd0 && !r_odd && r_first == '0))
        else $error("state not cleared after end of list");

    a_parity_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !i_last) |=> (r_odd != $past(r_odd)))
        else $error("position parity did not toggle");

endmodule

>>> hw/rtl/tpa_emit_stage.sv
// Corner range check, offset add and result register with output handshake.
module tpa_emit_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  tpa_pkg::t_tri_cand          i_cand,
    input  logic [tpa_pkg::VTX_W-1:0]   i_vertex_limit,
    input  logic [tpa_pkg::VTX_W-1:0]   i_base_offset,
    output logic                        o_ready,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [3*tpa_pkg::VTX_W-1:0] m_axis_tdata
);

    logic                        r_valid;
    logic [3*tpa_pkg::VTX_W-1:0] r_data;
    logic                        w_keep;

    assign o_ready = !r_valid || m_axis_tready;
    assign w_keep  = i_cand.valid
                  && (i_cand.a < i_vertex_limit)
                  && (i_cand.b < i_vertex_limit)
                  && (i_cand.c < i_vertex_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= w_keep;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Sums wrap at the index width.
    always_ff @(posedge i_clk) begin
        if (i_take && w_keep) begin
            r_data <= {i_cand.c + i_base_offset,
                       i_cand.b + i_base_offset,
                       i_cand.a + i_base_offset};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

endmodule
